[hw/rtl/nbpa_pkg.sv]
package nbpa_pkg;

    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned WORD_BITS  = 64;
    localparam int unsigned IN_W       = 152;
    localparam int unsigned OUT_W      = 72;

    typedef enum logic [1:0] {
        OP_REGISTER = 2'd0,
        OP_ALLOC    = 2'd1,
        OP_FREE     = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OOM       = 3'd1,
        ST_FULL      = 3'd2,
        ST_UNMATCHED = 3'd3,
        ST_DOUBLE    = 3'd4
    } status_t;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_AREAD = 7'b0000010,
        S_ACHK  = 7'b0000100,
        S_FSCAN = 7'b0001000,
        S_FREAD = 7'b0010000,
        S_FCHK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic           found;
        logic [5:0]     bit_idx;
    } zero_find_t;

    function automatic zero_find_t lowest_zero(input logic [WORD_BITS-1:0] word);
        zero_find_t r;
        r.found   = 1'b0;
        r.bit_idx = 6'd0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!word[i])
            begin
                r.found   = 1'b1;
                r.bit_idx = 6'(i);
            end
        end
        return r;
    endfunction

endpackage

[hw/rtl/nbpa_bitmap_ram.sv]
module nbpa_bitmap_ram #(
    parameter int unsigned AW = 13
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [AW-1:0]                     wr_addr,
    input  logic [nbpa_pkg::WORD_BITS-1:0]    wr_data,
    input  logic                              rd_en,
    input  logic [AW-1:0]                     rd_addr,
    output logic [nbpa_pkg::WORD_BITS-1:0]    rd_data
);

    logic [nbpa_pkg::WORD_BITS-1:0] mem [(1 << AW)];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/numa_bitmap_page_allocator.sv]
// NUMA bitmap page allocator.
// Input words arrive on s_tvalid/s_tready/s_tdata; one result word per input
// leaves on m_tvalid/m_tready/m_tdata. Opcode register appends a node, alloc
// returns the lowest free page (preferred node first), free releases a page.
// One item is worked on at a time; s_tready is high only while idle, so the
// next word is taken in the cycle after the previous result is loaded.
// Register goes straight to the done state; alloc reads and then checks one
// bitmap word at a time (S_AREAD, S_ACHK) through the single read port of
// the bitmap RAM; free compares the address with one node range per cycle,
// then reads and checks the bitmap word of the page.
// Each node keeps a count of bitmap words touched since registration; words
// at or above it read as clear, so registration needs no clearing pass.
// Reset empties the node table and drops any pending result.
// A stalled result holds in the output register; the block then finishes
// the next item and waits in its done state until the output frees up.
module numa_bitmap_page_allocator #(
    parameter int unsigned NODES = 8,
    parameter int unsigned PAGES = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[1:0], node_base[65:2], page_count[82:66], pref_node[86:83],
    // free_address[150:87]
    input  logic [nbpa_pkg::IN_W-1:0]       s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status[2:0], page_address[66:3]
    output logic [nbpa_pkg::OUT_W-1:0]      m_tdata
);

    localparam int unsigned W  = (PAGES + 63) / 64;
    localparam int unsigned WB = (W > 1) ? $clog2(W) : 1;
    localparam int unsigned HB = $clog2(W + 1);
    localparam int unsigned NB = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int unsigned CW = $clog2(NODES + 1);
    localparam int unsigned AW = NB + WB;
    localparam logic [16:0] PAGES_CAP = 17'(PAGES);

    logic [1:0]  in_opcode;
    logic [63:0] in_base;
    logic [16:0] in_count;
    logic [3:0]  in_pref;
    logic [63:0] in_faddr;

    assign in_opcode = s_tdata[1:0];
    assign in_base   = s_tdata[65:2];
    assign in_count  = s_tdata[82:66];
    assign in_pref   = s_tdata[86:83];
    assign in_faddr  = s_tdata[150:87];

    nbpa_pkg::state_t state_reg, state_next;

    logic [CW-1:0] nreg_reg, nreg_next;
    logic [63:0]   base_reg  [NODES];
    logic [16:0]   total_reg [NODES];
    logic [16:0]   free_reg  [NODES];
    logic [HB-1:0] hw_reg    [NODES];

    logic [NB-1:0] node_reg, node_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [WB-1:0] word_reg, word_next;
    logic [5:0]    bit_reg, bit_next;
    logic [63:0]   addr_reg, addr_next;
    logic [2:0]    res_st_reg, res_st_next;
    logic [63:0]   res_pa_reg, res_pa_next;

    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_st_reg, out_st_next;
    logic [63:0]   out_pa_reg, out_pa_next;

    logic                               accept;
    logic                               ram_we, ram_re;
    logic [AW-1:0]                      ram_waddr, ram_raddr;
    logic [nbpa_pkg::WORD_BITS-1:0]     ram_wdata, ram_rdata;
    logic [nbpa_pkg::WORD_BITS-1:0]     cur_word;
    nbpa_pkg::zero_find_t               zf;

    logic          pick_ok;
    logic [NB-1:0] pick_node;
    logic [16:0]   cap_count;
    logic [63:0]   diff;
    logic          range_hit;
    logic [16:0]   pidx;

    logic          tbl_reg_we;
    logic          tbl_alloc_we;
    logic          tbl_free_we;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == nbpa_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_pa_reg, out_st_reg};

    nbpa_bitmap_ram #(.AW(AW)) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        pick_ok   = 1'b0;
        pick_node = '0;
        for (int i = NODES - 1; i >= 0; i--)
        begin
            if ((CW'(i) < nreg_reg) && (free_reg[i] != 17'd0))
            begin
                pick_ok   = 1'b1;
                pick_node = NB'(i);
            end
        end
        if ((32'(in_pref) < 32'(nreg_reg)) && (32'(in_pref) < NODES))
        begin
            if (free_reg[NB'(in_pref)] != 17'd0)
            begin
                pick_ok   = 1'b1;
                pick_node = NB'(in_pref);
            end
        end
    end

    assign cap_count = ((in_count > PAGES_CAP) ? PAGES_CAP : in_count) & ~17'd7;

    assign diff      = addr_reg - base_reg[scan_reg[NB-1:0]];
    assign range_hit = (addr_reg >= base_reg[scan_reg[NB-1:0]])
                    && (diff[63:12] < 52'(total_reg[scan_reg[NB-1:0]]));
    assign pidx      = diff[28:12];

    assign cur_word = (HB'(word_reg) < hw_reg[node_reg]) ? ram_rdata : '0;
    assign zf       = nbpa_pkg::lowest_zero(cur_word);

    always_comb
    begin
        state_next   = state_reg;
        nreg_next    = nreg_reg;
        node_next    = node_reg;
        scan_next    = scan_reg;
        word_next    = word_reg;
        bit_next     = bit_reg;
        addr_next    = addr_reg;
        res_st_next  = res_st_reg;
        res_pa_next  = res_pa_reg;
        out_valid_next = out_valid_reg;
        out_st_next  = out_st_reg;
        out_pa_next  = out_pa_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_waddr    = {node_reg, word_reg};
        ram_raddr    = {node_reg, word_reg};
        ram_wdata    = cur_word;
        tbl_reg_we   = 1'b0;
        tbl_alloc_we = 1'b0;
        tbl_free_we  = 1'b0;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            nbpa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    res_st_next = nbpa_pkg::ST_OK;
                    res_pa_next = '0;
                    state_next  = nbpa_pkg::S_DONE;
                    case (in_opcode)
                        nbpa_pkg::OP_REGISTER:
                        begin
                            if (32'(nreg_reg) >= NODES)
                            begin
                                res_st_next = nbpa_pkg::ST_FULL;
                            end
                            else
                            begin
                                tbl_reg_we = 1'b1;
                                nreg_next  = nreg_reg + CW'(1);
                            end
                        end
                        nbpa_pkg::OP_ALLOC:
                        begin
                            if (pick_ok)
                            begin
                                node_next  = pick_node;
                                word_next  = '0;
                                state_next = nbpa_pkg::S_AREAD;
                            end
                            else
                            begin
                                res_st_next = nbpa_pkg::ST_OOM;
                            end
                        end
                        nbpa_pkg::OP_FREE:
                        begin
                            addr_next  = in_faddr;
                            scan_next  = '0;
                            state_next = nbpa_pkg::S_FSCAN;
                        end
                        default:
                        begin
                            state_next = nbpa_pkg::S_DONE;
                        end
                    endcase
                end
            end
            nbpa_pkg::S_AREAD:
            begin
                ram_re     = 1'b1;
                state_next = nbpa_pkg::S_ACHK;
            end
            nbpa_pkg::S_ACHK:
            begin
                if (zf.found)
                begin
                    ram_we       = 1'b1;
                    ram_wdata    = cur_word | (64'd1 << zf.bit_idx);
                    tbl_alloc_we = 1'b1;
                    res_pa_next  = base_reg[node_reg]
                                 + (64'({word_reg, zf.bit_idx}) << nbpa_pkg::PAGE_SHIFT);
                    state_next   = nbpa_pkg::S_DONE;
                end
                else
                begin
                    word_next  = word_reg + WB'(1);
                    state_next = nbpa_pkg::S_AREAD;
                end
            end
            nbpa_pkg::S_FSCAN:
            begin
                if (scan_reg >= nreg_reg)
                begin
                    res_st_next = nbpa_pkg::ST_UNMATCHED;
                    state_next  = nbpa_pkg::S_DONE;
                end
                else if (range_hit)
                begin
                    node_next = scan_reg[NB-1:0];
                    word_next = WB'(pidx >> 6);
                    bit_next  = pidx[5:0];
                    if (18'(pidx >> 6) >= 18'(hw_reg[scan_reg[NB-1:0]]))
                    begin
                        res_st_next = nbpa_pkg::ST_DOUBLE;
                        state_next  = nbpa_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = nbpa_pkg::S_FREAD;
                    end
                end
                else
                begin
                    scan_next = scan_reg + CW'(1);
                end
            end
            nbpa_pkg::S_FREAD:
            begin
                ram_re     = 1'b1;
                state_next = nbpa_pkg::S_FCHK;
            end
            nbpa_pkg::S_FCHK:
            begin
                if (cur_word[bit_reg])
                begin
                    ram_we      = 1'b1;
                    ram_wdata   = cur_word & ~(64'd1 << bit_reg);
                    tbl_free_we = 1'b1;
                    res_st_next = nbpa_pkg::ST_OK;
                end
                else
                begin
                    res_st_next = nbpa_pkg::ST_DOUBLE;
                end
                state_next = nbpa_pkg::S_DONE;
            end
            nbpa_pkg::S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_pa_next    = res_pa_reg;
                    state_next     = nbpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = nbpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nbpa_pkg::S_IDLE;
            nreg_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nreg_reg      <= nreg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        scan_reg   <= scan_next;
        word_reg   <= word_next;
        bit_reg    <= bit_next;
        addr_reg   <= addr_next;
        res_st_reg <= res_st_next;
        res_pa_reg <= res_pa_next;
        out_st_reg <= out_st_next;
        out_pa_reg <= out_pa_next;
    end

    always_ff @(posedge clk)
    begin
        if (tbl_reg_we)
        begin
            base_reg[nreg_reg[NB-1:0]]  <= in_base;
            total_reg[nreg_reg[NB-1:0]] <= cap_count;
            free_reg[nreg_reg[NB-1:0]]  <= cap_count;
            hw_reg[nreg_reg[NB-1:0]]    <= '0;
        end
        else if (tbl_alloc_we)
        begin
            free_reg[node_reg] <= free_reg[node_reg] - 17'd1;
            if (HB'(word_reg) == hw_reg[node_reg])
            begin
                hw_reg[node_reg] <= hw_reg[node_reg] + HB'(1);
            end
        end
        else if (tbl_free_we)
        begin
            free_reg[node_reg] <= free_reg[node_reg] + 17'd1;
        end
    end

endmodule

[hw/rtl/nbpa_checker.sv]
module nbpa_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic [nbpa_pkg::IN_W-1:0]    s_tdata,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [nbpa_pkg::OUT_W-1:0]   m_tdata
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[2:0] != nbpa_pkg::ST_OK) |-> (m_tdata[66:3] == 64'd0))
        else $error("page address nonzero on failure");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= nbpa_pkg::ST_DOUBLE))
        else $error("status code out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[1:0] != nbpa_pkg::OP_ALLOC)
        |=> m_tdata[66:3] == 64'd0 || !m_tvalid || $stable(m_tdata))
        else $error("address reported for non-allocate");

endmodule

bind numa_bitmap_page_allocator nbpa_checker u_nbpa_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
